FILE: rtl/byterun1_bitplane_row_decoder_unit_macros.svh
// Assertion macros used by the row decoder top level.
`ifndef BYTERUN1_BITPLANE_ROW_DECODER_UNIT_MACROS_SVH
`define BYTERUN1_BITPLANE_ROW_DECODER_UNIT_MACROS_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define BR1_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("row decoder: same-cycle check failed");

// Check that a consequent holds in the cycle after its antecedent.
`define BR1_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("row decoder: next-cycle check failed");

`endif

FILE: rtl/br1bpr_pkg.sv
// Shared types and constants of the ByteRun1 bitplane row decoder.
`timescale 1ns / 1ps
package br1bpr_pkg;

   localparam int CHUNK_BITS  = 16;
   localparam int MAX_PLANES  = 8;
   localparam int VIS_W       = 11;   // visible bits of one byte: up to 8 * 128

   localparam logic [7:0] SKIP_HEADER = 8'h80;

   // Register indexes of the configuration port
   localparam logic [1:0] REG_ROW_WIDTH   = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT   = 2'd1;
   localparam logic [1:0] REG_PLANE_COUNT = 2'd2;
   localparam logic [1:0] REG_MASK_ENABLE = 2'd3;

   localparam logic [15:0] ROW_WIDTH_RESET   = 16'd320;
   localparam logic [15:0] ROW_COUNT_RESET   = 16'd200;
   localparam logic [3:0]  PLANE_COUNT_RESET = 4'd5;
   localparam logic        MASK_ENABLE_RESET = 1'b0;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_LITERAL = 2'd1,
      PH_REPEAT  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [15:0] row_width;
      logic [15:0] row_count;
      logic [3:0]  plane_count;
      logic        mask_enable;
   } cfg_type;

   typedef struct packed {
      logic accept;   // input item taken this cycle
      logic emit;     // load the next result into the output register
   } cmd_type;

   typedef struct packed {
      logic is_data;     // item on the input is a data byte of a live image
      logic last_chunk;  // the pending result is the final one of its byte
      logic out_free;    // output register can take a result
   } status_type;

   typedef struct packed {
      logic [15:0] row_index;
      logic [2:0]  plane_index;
      logic        to_mask;
      logic [15:0] start_x;
      logic [15:0] pixel_bits;
      logic [4:0]  pixel_count;
      logic        pass_end;
      logic        image_end;
      logic        last;
   } result_type;

endpackage

FILE: rtl/br1bpr_ctrl.sv
// Controller state machine: sequences item intake and result emission.
`timescale 1ns / 1ps
module br1bpr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  br1bpr_pkg::status_type status,
   output br1bpr_pkg::cmd_type    cmd
);
   import br1bpr_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd.accept = req_valid && ready_ff;
      cmd.emit   = (state_ff == ST_EMIT) && status.out_free;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept && status.is_data) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cmd.emit && status.last_chunk) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

FILE: rtl/br1bpr_dp.sv
// Datapath: run decoding state, pass sequencing, chunking and output register.
`timescale 1ns / 1ps
module br1bpr_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  br1bpr_pkg::cfg_type    cfg,
   input  br1bpr_pkg::cmd_type    cmd,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_restart,
   input  logic                   rsp_ready,
   output br1bpr_pkg::status_type status,
   output logic                   rsp_valid,
   output br1bpr_pkg::result_type rsp_result
);
   import br1bpr_pkg::*;

   // Decoding state
   phase_type   phase_ff, phase_in;
   logic [6:0]  run_left_ff, run_left_in;
   logic [15:0] column_ff, column_in;
   logic [2:0]  plane_ff, plane_in;
   logic        mask_ff, mask_in;
   logic [15:0] row_ff, row_in;
   logic        finished_ff, finished_in;

   // Byte in flight
   logic [7:0]       byte_ff, byte_in;
   logic [VIS_W-1:0] remain_ff, remain_in;
   logic             pass_ff, pass_in;
   logic             img_ff, img_in;
   logic [2:0]       next_plane_ff, next_plane_in;
   logic             next_mask_ff, next_mask_in;
   logic             row_adv_ff, row_adv_in;

   // Output register
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;

   // State as seen by the item on the input, after an optional restart
   phase_type   phase_e;
   logic [6:0]  run_e;
   logic [15:0] column_e;
   logic [2:0]  plane_e;
   logic        mask_e;
   logic [15:0] row_e;
   logic        finished_e;
   logic        ignore;

   logic [7:0]       copies;
   logic [VIS_W-1:0] total;
   logic             done;
   logic             col_lt;
   logic [15:0]      diff;
   logic             fits;
   logic [VIS_W-1:0] visible;
   logic             pass_now;
   logic [3:0]       planes_eff;
   logic [3:0]       plane_inc;
   logic [2:0]       np;
   logic             nm;
   logic             adv;
   logic [16:0]      row_next;

   logic [4:0]  chunk_n;
   logic        last_chunk;
   logic [15:0] bits;

   always_comb begin
      phase_e    = req_restart ? PH_HEADER : phase_ff;
      run_e      = req_restart ? 7'd0  : run_left_ff;
      column_e   = req_restart ? 16'd0 : column_ff;
      plane_e    = req_restart ? 3'd0  : plane_ff;
      mask_e     = req_restart ? 1'b0  : mask_ff;
      row_e      = req_restart ? 16'd0 : row_ff;
      finished_e = req_restart ? 1'b0  : finished_ff;
      ignore     = finished_e || (row_e >= cfg.row_count);

      if (phase_e == PH_REPEAT) begin
         copies = {1'b0, run_e} + 8'd1;
         done   = 1'b1;
      end else begin
         copies = 8'd1;
         done   = (run_e == 7'd0);
      end
      total    = {copies, 3'b000};
      col_lt   = column_e < cfg.row_width;
      diff     = cfg.row_width - column_e;
      fits     = {{(16-VIS_W){1'b0}}, total} >= diff;
      visible  = !col_lt ? '0 : (fits ? diff[VIS_W-1:0] : total);
      pass_now = done && (!col_lt || fits);

      if (cfg.plane_count == 4'd0) begin
         planes_eff = 4'd1;
      end else if (cfg.plane_count > 4'(MAX_PLANES)) begin
         planes_eff = 4'(MAX_PLANES);
      end else begin
         planes_eff = cfg.plane_count;
      end
      plane_inc = {1'b0, plane_e} + 4'd1;
      if (mask_e) begin
         np  = 3'd0;
         nm  = 1'b0;
         adv = 1'b1;
      end else if (plane_inc >= planes_eff) begin
         np  = 3'd0;
         nm  = cfg.mask_enable;
         adv = !cfg.mask_enable;
      end else begin
         np  = plane_inc[2:0];
         nm  = 1'b0;
         adv = 1'b0;
      end
      row_next = {1'b0, row_e} + 17'd1;

      // Next chunk of the byte in flight
      last_chunk = remain_ff <= VIS_W'(CHUNK_BITS);
      chunk_n    = last_chunk ? remain_ff[4:0] : 5'(CHUNK_BITS);
      bits       = {byte_ff, byte_ff} & ~(16'hFFFF >> chunk_n);

      status.is_data    = !ignore && (phase_e == PH_LITERAL || phase_e == PH_REPEAT);
      status.last_chunk = last_chunk;
      status.out_free   = !out_valid_ff || rsp_ready;

      phase_in      = phase_ff;
      run_left_in   = run_left_ff;
      column_in     = column_ff;
      plane_in      = plane_ff;
      mask_in       = mask_ff;
      row_in        = row_ff;
      finished_in   = finished_ff;
      byte_in       = byte_ff;
      remain_in     = remain_ff;
      pass_in       = pass_ff;
      img_in        = img_ff;
      next_plane_in = next_plane_ff;
      next_mask_in  = next_mask_ff;
      row_adv_in    = row_adv_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_in        = out_ff;

      if (cmd.accept) begin
         phase_in    = phase_e;
         run_left_in = run_e;
         column_in   = column_e;
         plane_in    = plane_e;
         mask_in     = mask_e;
         row_in      = row_e;
         finished_in = finished_e;
         if (!ignore) begin
            unique case (phase_e)
               PH_LITERAL: begin
                  if (done) begin
                     phase_in    = PH_HEADER;
                     run_left_in = 7'd0;
                  end else begin
                     run_left_in = run_e - 7'd1;
                  end
               end
               PH_REPEAT: begin
                  phase_in    = PH_HEADER;
                  run_left_in = 7'd0;
               end
               default: begin
                  // Header: literal, repeat, or the no-op code
                  if (!req_data_byte[7]) begin
                     phase_in    = PH_LITERAL;
                     run_left_in = req_data_byte[6:0];
                  end else if (req_data_byte != SKIP_HEADER) begin
                     phase_in    = PH_REPEAT;
                     run_left_in = 7'(~req_data_byte + 8'd1);
                  end else begin
                     phase_in    = PH_HEADER;
                  end
               end
            endcase
         end
         if (status.is_data) begin
            byte_in       = req_data_byte;
            remain_in     = visible;
            pass_in       = pass_now;
            img_in        = pass_now && adv && (row_next >= {1'b0, cfg.row_count});
            next_plane_in = np;
            next_mask_in  = nm;
            row_adv_in    = adv;
         end
      end else if (cmd.emit) begin
         out_valid_in        = 1'b1;
         out_in.row_index    = row_ff;
         out_in.plane_index  = mask_ff ? 3'd1 : plane_ff;
         out_in.to_mask      = mask_ff;
         out_in.start_x      = column_ff;
         out_in.pixel_bits   = bits;
         out_in.pixel_count  = chunk_n;
         out_in.pass_end     = last_chunk && pass_ff;
         out_in.image_end    = last_chunk && img_ff;
         out_in.last         = last_chunk;
         remain_in           = remain_ff - VIS_W'(chunk_n);
         if (last_chunk && pass_ff) begin
            column_in   = 16'd0;
            plane_in    = next_plane_ff;
            mask_in     = next_mask_ff;
            row_in      = row_ff + {15'd0, row_adv_ff};
            finished_in = img_ff;
         end else begin
            column_in   = column_ff + {11'd0, chunk_n};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         run_left_ff  <= 7'd0;
         column_ff    <= 16'd0;
         plane_ff     <= 3'd0;
         mask_ff      <= 1'b0;
         row_ff       <= 16'd0;
         finished_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         run_left_ff  <= run_left_in;
         column_ff    <= column_in;
         plane_ff     <= plane_in;
         mask_ff      <= mask_in;
         row_ff       <= row_in;
         finished_ff  <= finished_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff       <= byte_in;
      remain_ff     <= remain_in;
      pass_ff       <= pass_in;
      img_ff        <= img_in;
      next_plane_ff <= next_plane_in;
      next_mask_ff  <= next_mask_in;
      row_adv_ff    <= row_adv_in;
      out_ff        <= out_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_ff;

endmodule

FILE: rtl/byterun1_bitplane_row_decoder_unit.sv
// Top level of the ByteRun1 bitplane row decoder.
`timescale 1ns / 1ps
`include "byterun1_bitplane_row_decoder_unit_macros.svh"
//
// Channel  | Direction | Item
// ---------+-----------+-----------------------------------------------------
// req_*    | in        | one compressed body byte, optional restart flag
// rsp_*    | out       | one chunk of up to 16 pixel bits of a row-plane pass
// csr_*    | in        | register write: row width, row count, planes, mask
//
// Header, no-op and ignored bytes leave intake open for the next item. A data byte
// closes intake once accepted and yields ceil(visible bits / 16) results,
// at least one, up to 64 for a long repeat run; the single chunking loop that
// drains the byte through the output register sets that figure.
// Reset is synchronous: state and configuration registers return to defaults, decoding restarts at
// row 0, plane 0, and req_tready rises the cycle after reset falls.
// rsp_tready low holds the waiting result and halts emission; input is taken
// again once the final result of a byte is in the output register.
module byterun1_bitplane_row_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   // Input channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] restart
   // Result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [15:0] row_index, [18:16] plane_index,
                                    // [34:19] start_x, [50:35] pixel_bits,
                                    // [55:51] pixel_count, [56] pass_end,
                                    // [57] image_end, [63:58] zero
   output logic        rsp_tuser,   // [0] to_mask
   output logic        rsp_tlast,   // final result of the accepted byte
   // Configuration port
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import br1bpr_pkg::*;

   cfg_type    cfg_ff;
   cmd_type    dp_cmd;
   status_type dp_status;
   result_type result;

   // Hold the configuration registers; the user must make writes only while idle, the block does not enforce it
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_width   <= ROW_WIDTH_RESET;
         cfg_ff.row_count   <= ROW_COUNT_RESET;
         cfg_ff.plane_count <= PLANE_COUNT_RESET;
         cfg_ff.mask_enable <= MASK_ENABLE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_ROW_WIDTH:   cfg_ff.row_width   <= csr_wdata;
            REG_ROW_COUNT:   cfg_ff.row_count   <= csr_wdata;
            REG_PLANE_COUNT: cfg_ff.plane_count <= csr_wdata[3:0];
            REG_MASK_ENABLE: cfg_ff.mask_enable <= csr_wdata[0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Controller: take an item while idle, then drain its results
   br1bpr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // Datapath: run parsing, pass sequencing and the output register
   br1bpr_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .cmd           (dp_cmd),
      .req_data_byte (req_tdata),
      .req_restart   (req_tuser),
      .rsp_ready     (rsp_tready),
      .status        (dp_status),
      .rsp_valid     (rsp_tvalid),
      .rsp_result    (result)
   );

   // Pack the result fields, lowest field first
   assign rsp_tdata = {6'd0,
                       result.image_end,
                       result.pass_end,
                       result.pixel_count,
                       result.pixel_bits,
                       result.start_x,
                       result.plane_index,
                       result.row_index};
   assign rsp_tuser = result.to_mask;
   assign rsp_tlast = result.last;

   // A result is loaded only while intake is closed and the slot is free
   `BR1_ASSERT_NOW(a_emit_closed, dp_cmd.emit, !req_tready && dp_status.out_free)
   // A data byte closes intake for at least the next cycle
   `BR1_ASSERT_NEXT(a_data_closes, dp_cmd.accept && dp_status.is_data, !req_tready)
   // The end of the image is also the end of a pass and of the byte's results
   `BR1_ASSERT_NOW(a_image_end, rsp_tvalid && rsp_tdata[57], rsp_tdata[56] && rsp_tlast)
   // A chunk never carries more than sixteen bits
   `BR1_ASSERT_NOW(a_chunk_size, rsp_tvalid, rsp_tdata[55:51] <= 5'd16)

endmodule

FILE: test/tb.sv
// Self-checking bench for the ByteRun1 bitplane row decoder: directed table plus random runs.
`timescale 1ns / 1ps
module tb;
   import br1bpr_pkg::*;

   localparam int HOLD_CYCLES   = 300;      // long receiver hold-off to back up the input
   localparam int SETTLE_CYCLES = 4;        // header and skip items leave no trace on rsp
   localparam int DRAIN_LIMIT   = 100000;
   localparam int RANDOM_QUOTA  = 60;       // items offered per random setting

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   // One line of the directed table: either an item or a register write.
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   data;
      logic         restart;
      logic [1:0]   addr;
      logic [15:0]  value;
      logic         typed;     // want holds the single chunk this item must produce
      result_type   want;
   } plan_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tuser;    // [0] restart
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;    // [15:0] row_index, [18:16] plane_index, [34:19] start_x,
                              // [50:35] pixel_bits, [55:51] pixel_count, [56] pass_end,
                              // [57] image_end
   logic        rsp_tuser;    // [0] to_mask
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   byterun1_bitplane_row_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Decoder mirror: register copies and run/pass position
   logic [15:0] cfg_row_width;
   logic [15:0] cfg_row_count;
   logic [3:0]  cfg_plane_count;
   logic        cfg_mask_enable;
   phase_type   dec_phase;
   logic [7:0]  dec_run_left;
   logic [15:0] dec_column;
   logic [2:0]  dec_plane;
   logic        dec_in_mask;
   logic [15:0] dec_row;
   logic        dec_finished;

   result_type   pending_chunks [$];    // chunks still owed by the block, oldest first
   plan_row_type plan [$];

   // Item side bookkeeping, shared among the driver, the monitor and the receiver
   logic        item_typed;
   result_type  item_want;
   logic        auto_restart;
   int          burst_left;
   logic        hold_request;
   logic        hold_taken;

   int fail_count;
   int mismatch_reports;
   int items_taken;
   int live_items;
   int chunks_checked;
   int pass_ends;
   int image_ends;

   function automatic void clear_decoder();
      dec_phase    = PH_HEADER;
      dec_run_left = '0;
      dec_column   = '0;
      dec_plane    = '0;
      dec_in_mask  = 1'b0;
      dec_row      = '0;
      dec_finished = 1'b0;
   endfunction

   // Work out the chunks owed for one accepted item and queue them.
   // Returns 1 unless the item falls after the end of the image.
   function automatic bit decode_byte(input logic [7:0] b, input logic restart);
      int copies, visible, pos, n, planes, p, i;
      bit run_done, pass_done, img_done;
      result_type chunk;
      pass_done = 0;
      img_done  = 0;
      run_done  = 0;
      copies    = 0;
      if (restart) clear_decoder();
      if (dec_finished || dec_row >= cfg_row_count) return 0;
      case (dec_phase)
         PH_LITERAL: begin
            copies   = 1;
            run_done = (dec_run_left == 0);
            if (!run_done) dec_run_left = dec_run_left - 8'd1;
         end
         PH_REPEAT: begin
            copies   = int'(dec_run_left) + 1;
            run_done = 1;
         end
         default: begin
            // header: open a literal or repeat run, or drop the skip code
            if (b < SKIP_HEADER) begin
               dec_phase    = PH_LITERAL;
               dec_run_left = b;
            end else if (b != SKIP_HEADER) begin
               dec_phase    = PH_REPEAT;
               dec_run_left = 8'(256 - int'(b));
            end else begin
               dec_phase = PH_HEADER;
            end
            return 1;
         end
      endcase

      // clip the run's bits at the row width
      visible = 0;
      if (dec_column < cfg_row_width) begin
         visible = int'(cfg_row_width) - int'(dec_column);
         if (visible > 8 * copies) visible = 8 * copies;
      end

      pos = 0;
      do begin
         n = visible - pos;
         if (n > CHUNK_BITS) n = CHUNK_BITS;
         chunk = '0;
         chunk.row_index   = dec_row;
         chunk.plane_index = dec_in_mask ? 3'd1 : dec_plane;
         chunk.to_mask     = dec_in_mask;
         chunk.start_x     = 16'(int'(dec_column) + pos);
         for (i = 0; i < n; i++) chunk.pixel_bits[CHUNK_BITS - 1 - i] = b[7 - ((pos + i) % 8)];
         chunk.pixel_count = 5'(n);
         pos += n;
         if (pos < visible) pending_chunks.push_back(chunk);
      end while (pos < visible);

      dec_column = 16'(int'(dec_column) + visible);
      if (run_done) begin
         dec_phase    = PH_HEADER;
         dec_run_left = '0;
         if (dec_column >= cfg_row_width) begin
            // step to the next plane, the mask pass or the next row
            pass_done = 1;
            planes = (cfg_plane_count == 0) ? 1 :
                     (cfg_plane_count > MAX_PLANES) ? MAX_PLANES : int'(cfg_plane_count);
            dec_column = '0;
            if (dec_in_mask) begin
               dec_in_mask = 1'b0;
               dec_plane   = '0;
               dec_row     = dec_row + 16'd1;
            end else begin
               p = int'(dec_plane) + 1;
               if (p >= planes) begin
                  dec_plane = '0;
                  if (cfg_mask_enable) dec_in_mask = 1'b1;
                  else dec_row = dec_row + 16'd1;
               end else begin
                  dec_plane = 3'(p);
               end
            end
            if (dec_row >= cfg_row_count) begin
               dec_finished = 1'b1;
               img_done     = 1;
            end
         end
      end
      chunk.pass_end  = pass_done;
      chunk.image_end = img_done;
      chunk.last      = 1'b1;
      pending_chunks.push_back(chunk);
      return 1;
   endfunction

   function automatic string describe(input result_type r);
      return $sformatf("row %0d plane %0d mask %0b x %0d bits %h n %0d pe %0b ie %0b last %0b",
                       r.row_index, r.plane_index, r.to_mask, r.start_x, r.pixel_bits,
                       r.pixel_count, r.pass_end, r.image_end, r.last);
   endfunction

   function automatic result_type chunk_of(input int row, input int plane, input int to_mask,
                                           input int x, input int bits, input int count,
                                           input int pe, input int ie);
      result_type r;
      r.row_index   = 16'(row);
      r.plane_index = 3'(plane);
      r.to_mask     = 1'(to_mask);
      r.start_x     = 16'(x);
      r.pixel_bits  = 16'(bits);
      r.pixel_count = 5'(count);
      r.pass_end    = 1'(pe);
      r.image_end   = 1'(ie);
      r.last        = 1'b1;
      return r;
   endfunction

   function automatic plan_row_type mk_item(input logic [7:0] b, input logic restart);
      plan_row_type r;
      r = '0;
      r.kind    = ROW_ITEM;
      r.data    = b;
      r.restart = restart;
      return r;
   endfunction

   function automatic plan_row_type mk_check(input logic [7:0] b, input logic restart,
                                             input result_type want);
      plan_row_type r;
      r       = mk_item(b, restart);
      r.typed = 1'b1;
      r.want  = want;
      return r;
   endfunction

   function automatic plan_row_type mk_csr(input logic [1:0] addr, input logic [15:0] value);
      plan_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.addr  = addr;
      r.value = value;
      return r;
   endfunction

   // Clock: 12 ns period
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #8000000;
      $display("FAIL byterun1_bitplane_row_decoder_unit");
      $finish;
   end

   // Monitor: mirror register writes, predict on each accepted item and check each result
   always @(posedge clock) begin : monitor
      result_type got, want;
      int queued;
      logic bad;
      if (reset) begin
         cfg_row_width   = ROW_WIDTH_RESET;
         cfg_row_count   = ROW_COUNT_RESET;
         cfg_plane_count = PLANE_COUNT_RESET;
         cfg_mask_enable = MASK_ENABLE_RESET;
         clear_decoder();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_ROW_WIDTH:   cfg_row_width   = csr_wdata;
               REG_ROW_COUNT:   cfg_row_count   = csr_wdata;
               REG_PLANE_COUNT: cfg_plane_count = csr_wdata[3:0];
               REG_MASK_ENABLE: cfg_mask_enable = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            queued = pending_chunks.size();
            if (decode_byte(req_tdata, req_tuser)) live_items++;
            items_taken++;
            // a typed table row replaces what the mirror worked out
            if (item_typed) begin
               while (pending_chunks.size() > queued) void'(pending_chunks.pop_back());
               pending_chunks.push_back(item_want);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.row_index   = rsp_tdata[15:0];
            got.plane_index = rsp_tdata[18:16];
            got.start_x     = rsp_tdata[34:19];
            got.pixel_bits  = rsp_tdata[50:35];
            got.pixel_count = rsp_tdata[55:51];
            got.pass_end    = rsp_tdata[56];
            got.image_end   = rsp_tdata[57];
            got.to_mask     = rsp_tuser;
            got.last        = rsp_tlast;
            if (pending_chunks.size() == 0) begin
               fail_count++;
               if (mismatch_reports < 10) begin
                  mismatch_reports++;
                  $display("%0t: unexpected chunk: %s", $time, describe(got));
               end
            end else begin
               want = pending_chunks.pop_front();
               chunks_checked++;
               if (want.pass_end) pass_ends++;
               if (want.image_end) image_ends++;
               bad = (got.row_index !== want.row_index) || (got.plane_index !== want.plane_index)
                  || (got.to_mask !== want.to_mask) || (got.start_x !== want.start_x)
                  || (got.pixel_bits !== want.pixel_bits)
                  || (got.pixel_count !== want.pixel_count)
                  || (got.pass_end !== want.pass_end) || (got.image_end !== want.image_end)
                  || (got.last !== want.last);
               if (bad) begin
                  fail_count++;
                  if (mismatch_reports < 10) begin
                     mismatch_reports++;
                     $display("%0t: chunk mismatch\n  want %s\n  got  %s", $time,
                              describe(want), describe(got));
                  end
               end
            end
         end
      end
   end

   // Receiver: switch between random stall patterns, honour one long hold-off on request
   initial begin : receiver
      int cyc;
      int mode;
      int hold_left;
      cyc        = 0;
      mode       = 0;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc % 64 == 0) mode = $urandom_range(0, 3);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            case (mode)
               0:       rsp_tready = 1'b1;
               1:       rsp_tready = 1'($urandom_range(0, 1));
               2:       rsp_tready = (cyc % 4 == 0);
               default: rsp_tready = ($urandom_range(0, 4) != 0);
            endcase
         end
      end
   end

   // Offer one item; bursts of random length with random gaps between them.
   task automatic send_item(input logic [7:0] b, input logic restart, input logic typed,
                            input result_type want);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
      end
      req_tdata  = b;
      // once the image is complete or out of rows, restart it so random bytes keep decoding
      req_tuser  = restart | (auto_restart & (dec_finished | (dec_row >= cfg_row_count)));
      item_typed = typed;
      item_want  = want;
      req_tvalid = 1'b1;
      burst_left--;
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid and wait until every owed chunk is out and the block is quiet.
   task automatic settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending_chunks.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] addr, input logic [15:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_addr  = addr;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic configure(input logic [15:0] width, input logic [15:0] rows,
                            input logic [3:0] planes, input logic mask);
      settle();
      write_reg(REG_ROW_WIDTH, width);
      write_reg(REG_ROW_COUNT, rows);
      write_reg(REG_PLANE_COUNT, 16'(planes));
      write_reg(REG_MASK_ENABLE, 16'(mask));
   endtask

   // Mostly well-formed runs with random content, some skips, noise and restarts.
   task automatic random_runs(input int quota);
      int sent, pick, n, k;
      logic rs;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(0, 99);
         rs   = ($urandom_range(0, 29) == 0);
         if (pick < 45) begin
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
            // keep a long literal within the items left for this setting
            if (n > quota - sent - 2) n = (quota - sent - 2 > 0) ? quota - sent - 2 : 0;
            send_item(8'(n), rs, 1'b0, '0);
            for (k = 0; k <= n; k++)
               send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 59) == 0), 1'b0, '0);
            sent += n + 2;
         end else if (pick < 85) begin
            case ($urandom_range(0, 5))
               0:       n = 1;
               1:       n = 127;
               default: n = $urandom_range(1, 127);
            endcase
            send_item(8'(256 - n), rs, 1'b0, '0);
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, '0);
            sent += 2;
         end else if (pick < 90) begin
            send_item(SKIP_HEADER, rs, 1'b0, '0);
            sent += 1;
         end else begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
            sent += 1;
         end
      end
   endtask

   // Stimulus: reset, directed table, then random runs over several register settings
   initial begin : stimulus
      int guard;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      csr_we       = 1'b0;
      csr_addr     = REG_ROW_WIDTH;
      csr_wdata    = '0;
      item_typed   = 1'b0;
      item_want    = '0;
      auto_restart = 1'b0;
      burst_left   = 0;
      hold_request = 1'b0;
      fail_count       = 0;
      mismatch_reports = 0;
      items_taken      = 0;
      live_items       = 0;
      chunks_checked   = 0;
      pass_ends        = 0;
      image_ends       = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings (width 320, 200 rows, 5 planes, no mask), then a
      // one-pixel, one-row image with a mask pass to reach clipping and image end.
      plan = '{
         mk_item(SKIP_HEADER, 1'b0),                                   // skip code
         mk_item(8'h00, 1'b0),                                         // literal of one
         mk_check(8'hA5, 1'b0, chunk_of(0, 0, 0, 0, 'hA500, 8, 0, 0)),
         mk_item(8'h01, 1'b0),                                         // literal of two
         mk_check(8'hFF, 1'b0, chunk_of(0, 0, 0, 8, 'hFF00, 8, 0, 0)),
         mk_check(8'h00, 1'b0, chunk_of(0, 0, 0, 16, 'h0000, 8, 0, 0)),
         mk_item(8'h81, 1'b0),                                         // longest repeat
         mk_item(8'h3C, 1'b0),                                         // clipped, ends pass
         mk_item(8'hFF, 1'b0),                                         // shortest repeat
         mk_item(8'h5A, 1'b0),
         mk_item(8'h7F, 1'b1),                                         // restart, long literal
         mk_check(8'h12, 1'b0, chunk_of(0, 0, 0, 0, 'h1200, 8, 0, 0)),
         mk_item(SKIP_HEADER, 1'b1),                                   // restart on a skip
         mk_csr(REG_ROW_WIDTH, 16'd1),
         mk_csr(REG_ROW_COUNT, 16'd1),
         mk_csr(REG_PLANE_COUNT, 16'd1),
         mk_csr(REG_MASK_ENABLE, 16'd1),
         mk_item(8'h01, 1'b1),
         mk_check(8'h80, 1'b0, chunk_of(0, 0, 0, 0, 'h8000, 1, 0, 0)),
         mk_check(8'hC3, 1'b0, chunk_of(0, 0, 0, 1, 'h0000, 0, 1, 0)), // all clipped
         mk_item(8'hFE, 1'b0),
         mk_check(8'h7F, 1'b0, chunk_of(0, 1, 1, 0, 'h0000, 1, 1, 1)), // mask pass ends image
         mk_item(8'h00, 1'b0),                                         // ignored after the end
         mk_item(8'hFF, 1'b0)
      };
      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            settle();
            write_reg(plan[i].addr, plan[i].value);
         end else begin
            send_item(plan[i].data, plan[i].restart, plan[i].typed, plan[i].want);
         end
      end

      // Random part: one setting per phase, the extremes among them
      auto_restart = 1'b1;
      configure(16'd37, 16'd3, 4'd2, 1'b1);
      random_runs(RANDOM_QUOTA);
      configure(16'd1, 16'd65535, 4'd8, 1'b0);
      random_runs(RANDOM_QUOTA);
      // widest rows: repeat runs give up to 64 chunks, so hold the receiver off here
      configure(16'd65535, 16'd1, 4'd1, 1'b1);
      hold_request = 1'b1;
      random_runs(RANDOM_QUOTA);
      configure(16'($urandom_range(1, 80)), 16'($urandom_range(1, 4)),
                4'($urandom_range(1, 8)), 1'($urandom_range(0, 1)));
      random_runs(RANDOM_QUOTA);

      // Drain: wait for the owed chunks, then a little longer for strays
      @(negedge clock);
      req_tvalid = 1'b0;
      guard = 0;
      while (pending_chunks.size() != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      repeat (5 * SETTLE_CYCLES) @(negedge clock);
      if (pending_chunks.size() != 0) begin
         fail_count += pending_chunks.size();
         $display("%0d chunks never arrived", pending_chunks.size());
      end

      $display("Ran %0d items (%0d decoded), checked %0d chunks with %0d pass ends, %0d image ends",
               items_taken, live_items, chunks_checked, pass_ends, image_ends);
      $display("Widths 1..65535, 1..65535 rows, 1..8 planes, mask on and off; %0d failures",
               fail_count);
      if (fail_count == 0) begin
         $display("PASS byterun1_bitplane_row_decoder_unit");
      end else begin
         $display("FAIL byterun1_bitplane_row_decoder_unit");
      end
      $finish;
   end

endmodule

FILE: byterun1_bitplane_row_decoder_unit.f
+incdir+rtl
rtl/br1bpr_pkg.sv
rtl/br1bpr_ctrl.sv
rtl/br1bpr_dp.sv
rtl/byterun1_bitplane_row_decoder_unit.sv
test/tb.sv
